[rtl/core/astm_pkg.sv]
package astm_pkg;

   // Default upper limit on the length of one received buffer.
   localparam int DEFAULT_MAX_BUFFER_BYTES = 1024;

   localparam int TAIL_DEPTH = 6;

   // Control characters of the link protocol.
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ENQ = 8'h05;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_ETB = 8'h17;

   // Printable characters used by the digit and checksum checks.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [7:0] MAX_FRAME_DIGIT = 8'd7;
   localparam int         MIN_TEXT_BYTES  = 8;

   // Frame type codes.
   localparam logic [2:0] FT_UNKNOWN = 3'd0;
   localparam logic [2:0] FT_ACK     = 3'd1;
   localparam logic [2:0] FT_ENQ     = 3'd2;
   localparam logic [2:0] FT_EOT     = 3'd3;
   localparam logic [2:0] FT_NAK     = 3'd4;
   localparam logic [2:0] FT_TEXT    = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_MALFORMED  = 2'd1;
   localparam logic [1:0] ST_LF_MISSING = 2'd2;

   typedef struct packed {
      logic [2:0]  frame_type;
      logic [1:0]  status;
      logic [2:0]  frame_seq;
      logic        etx_closed;
      logic [7:0]  received_checksum;
      logic [9:0]  payload_size;
      logic [10:0] frame_length;
   } verdict_type;

endpackage

[rtl/core/astm_req_if.sv]
interface astm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/core/astm_rsp_if.sv]
interface astm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_type;
   logic [1:0]  status;
   logic [2:0]  frame_seq;
   logic        etx_closed;
   logic [7:0]  received_checksum;
   logic [9:0]  payload_size;
   logic [10:0] frame_length;

   modport source (output valid, output frame_type, output status, output frame_seq,
                   output etx_closed, output received_checksum, output payload_size,
                   output frame_length, input ready);
   modport sink (input valid, input frame_type, input status, input frame_seq,
                 input etx_closed, input received_checksum, input payload_size,
                 input frame_length, output ready);
endinterface

[rtl/core/astm_frame_judge.sv]
module astm_frame_judge #(
   parameter int MAX_BUFFER_BYTES = astm_pkg::DEFAULT_MAX_BUFFER_BYTES,
   localparam int CW = $clog2(MAX_BUFFER_BYTES + 2)
) (
   input  logic [7:0]            lead_byte,
   input  logic [7:0]            digit_byte,
   input  logic [CW-1:0]         byte_count,
   input  logic [7:0]            running_sum,
   input  logic [7:0]            tail_history [astm_pkg::TAIL_DEPTH],
   output astm_pkg::verdict_type verdict
);

   localparam int EW = (CW > 11) ? CW : 11;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= astm_pkg::CH_ZERO && c <= astm_pkg::CH_NINE) ||
             (c >= astm_pkg::CH_UPPER_A && c <= astm_pkg::CH_UPPER_F) ||
             (c >= astm_pkg::CH_LOWER_A && c <= astm_pkg::CH_LOWER_F);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= astm_pkg::CH_ZERO && c <= astm_pkg::CH_NINE) begin
         v = c - astm_pkg::CH_ZERO;
      end else if (c >= astm_pkg::CH_UPPER_A && c <= astm_pkg::CH_UPPER_F) begin
         v = c - astm_pkg::CH_UPPER_A + 8'd10;
      end else begin
         v = c - astm_pkg::CH_LOWER_A + 8'd10;
      end
      return v[3:0];
   endfunction

   logic [EW-1:0] count_ext;
   logic [7:0]    digit_value;
   logic [7:0]    checksum;
   logic [7:0]    body_sum;
   logic          size_bad;
   logic          trailer_bad;

   assign count_ext   = EW'(byte_count);
   assign digit_value = digit_byte - astm_pkg::CH_ZERO;
   assign checksum    = {hex_value(tail_history[3]), hex_value(tail_history[2])};
   // The running sum covers every byte after STX; take off the CR, LF and
   // the two checksum digits to leave the span from the frame digit to ETB/ETX.
   assign body_sum    = running_sum - tail_history[0] - tail_history[1] -
                        tail_history[2] - tail_history[3];
   assign size_bad    = (count_ext < EW'(astm_pkg::MIN_TEXT_BYTES)) ||
                        (count_ext > EW'(MAX_BUFFER_BYTES));
   assign trailer_bad = (tail_history[1] != astm_pkg::CH_CR) ||
                        !is_hex(tail_history[2]) || !is_hex(tail_history[3]) ||
                        ((tail_history[4] != astm_pkg::CH_ETB) &&
                         (tail_history[4] != astm_pkg::CH_ETX)) ||
                        (tail_history[5] != astm_pkg::CH_CR);

   always_comb begin
      verdict = '0;
      case (lead_byte)
         astm_pkg::CH_ACK: begin
            verdict.frame_type   = astm_pkg::FT_ACK;
            verdict.frame_length = 11'd1;
         end
         astm_pkg::CH_ENQ: begin
            verdict.frame_type   = astm_pkg::FT_ENQ;
            verdict.frame_length = 11'd1;
         end
         astm_pkg::CH_EOT: begin
            verdict.frame_type   = astm_pkg::FT_EOT;
            verdict.frame_length = 11'd1;
         end
         astm_pkg::CH_NAK: begin
            verdict.frame_type   = astm_pkg::FT_NAK;
            verdict.frame_length = 11'd1;
         end
         astm_pkg::CH_STX: begin
            if (size_bad || digit_value > astm_pkg::MAX_FRAME_DIGIT) begin
               verdict.status = astm_pkg::ST_MALFORMED;
            end else if (tail_history[0] != astm_pkg::CH_LF) begin
               verdict.status = astm_pkg::ST_LF_MISSING;
            end else if (trailer_bad || body_sum != checksum) begin
               verdict.status = astm_pkg::ST_MALFORMED;
            end else begin
               verdict.frame_type        = astm_pkg::FT_TEXT;
               verdict.frame_seq         = digit_value[2:0];
               verdict.etx_closed        = (tail_history[4] == astm_pkg::CH_ETX);
               verdict.received_checksum = checksum;
               verdict.payload_size      =
                  10'(count_ext - EW'(astm_pkg::MIN_TEXT_BYTES));
               verdict.frame_length      = 11'(count_ext);
            end
         end
         default: begin
            verdict.status = astm_pkg::ST_MALFORMED;
         end
      endcase
   end

endmodule

[rtl/core/astm_e1381_frame_parser.sv]
// Takes one byte per cycle, back to back, with no bubbles between buffers, except
// while the snapshot is held up as described below. The verdict of the last-byte
// beat passes through the buffer snapshot register and then the result register.
// Bytes without the last flag give no result; while a verdict waits in the
// snapshot behind a stalled result, no beat is taken. Synchronous active-high
// reset clears the accumulators and both valid flags; nothing needs a clearing pass.
module astm_e1381_frame_parser #(
   parameter int MAX_BUFFER_BYTES = astm_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
   input logic         clock,
   input logic         reset,
   astm_req_if.sink    req_bus,
   astm_rsp_if.source  rsp_bus
);

   localparam int CW    = $clog2(MAX_BUFFER_BYTES + 2);
   localparam int DEPTH = astm_pkg::TAIL_DEPTH;

   // Accumulators for the buffer being received.
   logic [7:0]    lead_ff, lead_in;
   logic [7:0]    digit_ff, digit_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    tail_ff [DEPTH];
   logic [7:0]    tail_in [DEPTH];

   // Snapshot of a finished buffer, waiting for its verdict.
   logic          snap_valid_ff, snap_valid_in;
   logic [7:0]    snap_lead_ff;
   logic [7:0]    snap_digit_ff;
   logic [CW-1:0] snap_count_ff;
   logic [7:0]    snap_sum_ff;
   logic [7:0]    snap_tail_ff [DEPTH];

   logic                  rsp_valid_ff, rsp_valid_in;
   astm_pkg::verdict_type rsp_data_ff;
   astm_pkg::verdict_type verdict;

   logic accept;
   logic advance;

   assign advance       = snap_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !snap_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      lead_in  = (count_ff == '0) ? req_bus.data_byte : lead_ff;
      digit_in = (count_ff == CW'(1)) ? req_bus.data_byte : digit_ff;
      sum_in   = (count_ff == '0) ? sum_ff : sum_ff + req_bus.data_byte;
      count_in = (count_ff <= CW'(MAX_BUFFER_BYTES)) ? count_ff + CW'(1) : count_ff;
      tail_in[0] = req_bus.data_byte;
      for (int i = 1; i < DEPTH; i++) begin
         tail_in[i] = tail_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         digit_ff <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            tail_ff[i] <= '0;
         end
      end else if (accept) begin
         if (req_bus.last_byte) begin
            lead_ff  <= '0;
            digit_ff <= '0;
            count_ff <= '0;
            sum_ff   <= '0;
            for (int i = 0; i < DEPTH; i++) begin
               tail_ff[i] <= '0;
            end
         end else begin
            lead_ff  <= lead_in;
            digit_ff <= digit_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            tail_ff  <= tail_in;
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (accept && req_bus.last_byte) begin
         snap_valid_in = 1'b1;
      end else if (advance) begin
         snap_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.last_byte) begin
         snap_lead_ff  <= lead_in;
         snap_digit_ff <= digit_in;
         snap_count_ff <= count_in;
         snap_sum_ff   <= sum_in;
         snap_tail_ff  <= tail_in;
      end
      if (advance) begin
         rsp_data_ff <= verdict;
      end
   end

   astm_frame_judge #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_judge (
      .lead_byte    (snap_lead_ff),
      .digit_byte   (snap_digit_ff),
      .byte_count   (snap_count_ff),
      .running_sum  (snap_sum_ff),
      .tail_history (snap_tail_ff),
      .verdict      (verdict)
   );

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.frame_type        = rsp_data_ff.frame_type;
   assign rsp_bus.status            = rsp_data_ff.status;
   assign rsp_bus.frame_seq         = rsp_data_ff.frame_seq;
   assign rsp_bus.etx_closed        = rsp_data_ff.etx_closed;
   assign rsp_bus.received_checksum = rsp_data_ff.received_checksum;
   assign rsp_bus.payload_size      = rsp_data_ff.payload_size;
   assign rsp_bus.frame_length      = rsp_data_ff.frame_length;

   // The byte counter saturates one above the limit.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BUFFER_BYTES + 1))
      else $error("byte counter ran past its saturation value");

   // A last-byte beat always lands in the snapshot register.
   a_last_snapped: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_byte |=> snap_valid_ff)
      else $error("finished buffer not captured");

   // A verdict moved out of the snapshot is offered on the next cycle.
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("verdict lost between snapshot and result register");

   // A failed frame carries no length and an unknown frame type.
   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != astm_pkg::ST_OK |->
         rsp_data_ff.frame_length == '0 && rsp_data_ff.frame_type == astm_pkg::FT_UNKNOWN)
      else $error("error verdict with non-zero fields");

   // A good text frame is at least as long as its fixed framing.
   a_text_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_type == astm_pkg::FT_TEXT |->
         rsp_data_ff.status == astm_pkg::ST_OK &&
         (rsp_data_ff.frame_length >= 11'(astm_pkg::MIN_TEXT_BYTES) ||
          MAX_BUFFER_BYTES > 2047))
      else $error("text verdict shorter than its framing");

endmodule

[verif/astm_e1381_frame_parser_tb.sv]
module astm_e1381_frame_parser_tb;
   import astm_pkg::*;

   localparam int MAX_BYTES    = DEFAULT_MAX_BUFFER_BYTES;
   localparam int RANDOM_BEATS = 200;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_pattern_type;

   // Predicts the verdict of each buffer from its beats and checks the block's results.
   class verdict_scoreboard;
      logic [7:0]  lead_char;
      logic [7:0]  digit_char;
      int unsigned byte_total;
      logic [7:0]  byte_sum;
      logic [7:0]  recent[6];
      verdict_type pending_verdicts[$];
      int unsigned failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         lead_char  = '0;
         digit_char = '0;
         byte_total = 0;
         byte_sum   = '0;
         foreach (recent[i]) recent[i] = '0;
      endfunction

      function bit is_hex(logic [7:0] c);
         return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                (c >= CH_LOWER_A && c <= CH_LOWER_F);
      endfunction

      function logic [3:0] nibble_of(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
         if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 4'(c - CH_UPPER_A + 8'd10);
         return 4'(c - CH_LOWER_A + 8'd10);
      endfunction

      function verdict_type judge_text();
         verdict_type v;
         logic [7:0]  number;
         logic [7:0]  sent_sum;
         logic [7:0]  body_sum;
         v = '0;
         if (byte_total < MIN_TEXT_BYTES || byte_total > MAX_BYTES) begin
            v.status = ST_MALFORMED;
            return v;
         end
         number = digit_char - CH_ZERO;
         if (number > MAX_FRAME_DIGIT) begin
            v.status = ST_MALFORMED;
            return v;
         end
         if (recent[0] != CH_LF) begin
            v.status = ST_LF_MISSING;
            return v;
         end
         if (recent[1] != CH_CR || !is_hex(recent[2]) || !is_hex(recent[3]) ||
             (recent[4] != CH_ETB && recent[4] != CH_ETX) || recent[5] != CH_CR) begin
            v.status = ST_MALFORMED;
            return v;
         end
         sent_sum = {nibble_of(recent[3]), nibble_of(recent[2])};
         // The running sum covers everything after STX; strip the four trailing bytes.
         body_sum = byte_sum - recent[0] - recent[1] - recent[2] - recent[3];
         if (body_sum != sent_sum) begin
            v.status = ST_MALFORMED;
            return v;
         end
         v.frame_type        = FT_TEXT;
         v.frame_seq         = number[2:0];
         v.etx_closed        = (recent[4] == CH_ETX);
         v.received_checksum = sent_sum;
         v.payload_size      = 10'(byte_total - MIN_TEXT_BYTES);
         v.frame_length      = 11'(byte_total);
         return v;
      endfunction

      function void note_beat(logic [7:0] b, logic last);
         verdict_type v;
         if (byte_total == 0) lead_char = b;
         else byte_sum = byte_sum + b;
         if (byte_total == 1) digit_char = b;
         if (byte_total <= MAX_BYTES) byte_total++;
         for (int i = 5; i > 0; i--) recent[i] = recent[i-1];
         recent[0] = b;
         if (!last) return;
         v = '0;
         case (lead_char)
            CH_ACK: begin
               v.frame_type   = FT_ACK;
               v.frame_length = 11'd1;
            end
            CH_ENQ: begin
               v.frame_type   = FT_ENQ;
               v.frame_length = 11'd1;
            end
            CH_EOT: begin
               v.frame_type   = FT_EOT;
               v.frame_length = 11'd1;
            end
            CH_NAK: begin
               v.frame_type   = FT_NAK;
               v.frame_length = 11'd1;
            end
            CH_STX: v = judge_text();
            default: v.status = ST_MALFORMED;
         endcase
         pending_verdicts.push_back(v);
         restart();
      endfunction

      function string describe(verdict_type v);
         return $sformatf("type=%0d status=%0d seq=%0d etx=%0d checksum=%02h size=%0d len=%0d",
                          v.frame_type, v.status, v.frame_seq, v.etx_closed,
                          v.received_checksum, v.payload_size, v.frame_length);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            flag({"unexpected verdict: ", describe(got)});
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.frame_type !== want.frame_type || got.status !== want.status ||
             got.frame_seq !== want.frame_seq || got.etx_closed !== want.etx_closed ||
             got.received_checksum !== want.received_checksum ||
             got.payload_size !== want.payload_size || got.frame_length !== want.frame_length)
            flag({"verdict mismatch: expected ", describe(want), " got ", describe(got)});
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   astm_req_if req_bus();
   astm_rsp_if rsp_bus();

   astm_e1381_frame_parser #(
      .MAX_BUFFER_BYTES(MAX_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   verdict_scoreboard sb;
   logic [7:0]  frame_bytes[$];
   int          burst_left;
   bit          steady_sender;
   bit          hold_wanted;
   bit          hold_active;
   int unsigned beats_sent;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL astm_e1381_frame_parser");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_beat(req_bus.data_byte, req_bus.last_byte);

   always @(posedge clock) begin
      verdict_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.frame_type        = rsp_bus.frame_type;
         got.status            = rsp_bus.status;
         got.frame_seq         = rsp_bus.frame_seq;
         got.etx_closed        = rsp_bus.etx_closed;
         got.received_checksum = rsp_bus.received_checksum;
         got.payload_size      = rsp_bus.payload_size;
         got.frame_length      = rsp_bus.frame_length;
         sb.check_verdict(got);
      end
   end

   // Result side: stretches of different stall patterns, plus one long hold-off on request.
   initial begin : result_sink
      rx_pattern_type pattern;
      int stretch;
      forever begin
         if (hold_wanted) begin
            hold_active = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
            hold_wanted = 1'b0;
         end else begin
            pattern = rx_pattern_type'($urandom_range(0, 3));
            stretch = $urandom_range(16, 160);
            for (int i = 0; i < stretch && !hold_wanted; i++) begin
               case (pattern)
                  RX_ALWAYS: rsp_bus.ready <= 1'b1;
                  RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp_bus.ready <= (i % 4 == 3);
                  default:   rsp_bus.ready <= (i % 12 < 7);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 4'd10) return CH_ZERO + 8'(n);
      return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] control_char(int k);
      case (k)
         0: return CH_ACK;
         1: return CH_ENQ;
         2: return CH_EOT;
         default: return CH_NAK;
      endcase
   endfunction

   // Lays out a well-formed text frame with random payload in frame_bytes.
   function automatic void build_text(logic [7:0] digit, int payload_len, logic [7:0] closer,
                                      bit lower);
      logic [7:0] csum;
      logic [7:0] b;
      frame_bytes.delete();
      frame_bytes.push_back(CH_STX);
      frame_bytes.push_back(digit);
      csum = digit;
      repeat (payload_len) begin
         b = 8'($urandom);
         frame_bytes.push_back(b);
         csum = csum + b;
      end
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(closer);
      csum = csum + CH_CR + closer;
      frame_bytes.push_back(hex_char(csum[7:4], lower));
      frame_bytes.push_back(hex_char(csum[3:0], lower));
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
   endfunction

   function automatic void poke(int from_end, logic [7:0] b);
      frame_bytes[frame_bytes.size() - from_end] = b;
   endfunction

   function automatic void corrupt_text();
      int n;
      n = frame_bytes.size();
      case ($urandom_range(0, 3))
         0: frame_bytes[($urandom_range(0, 3) == 0) ? 1 : n - $urandom_range(1, 6)] = 8'($urandom);
         1: poke($urandom_range(3, 4), hex_char(4'($urandom), 1'($urandom_range(0, 1))));
         2: repeat ($urandom_range(1, n - 1)) void'(frame_bytes.pop_back());
         default: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      endcase
   endfunction

   task automatic send_beat(logic [7:0] b, logic last);
      if (!steady_sender && burst_left == 0) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'($urandom);
         req_bus.last_byte <= 1'($urandom);
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic send_random_buffer();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         build_text(CH_ZERO + 8'($urandom_range(0, 7)),
                    ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24),
                    $urandom_range(0, 1) ? CH_ETX : CH_ETB, 1'($urandom_range(0, 1)));
         if (pick >= 55) corrupt_text();
      end else if (pick < 88) begin
         frame_bytes.delete();
         frame_bytes.push_back(control_char($urandom_range(0, 3)));
         repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.delete();
         frame_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_STX : 8'($urandom));
         repeat ($urandom_range(0, 11)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
   endtask

   initial begin : stimulus
      int unsigned start_beats;
      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Control frames, including one whose trailing bytes must be ignored, and two bad lead bytes.
      for (int k = 0; k < 4; k++) begin
         frame_bytes = {control_char(k)};
         send_frame();
      end
      frame_bytes = {CH_ACK, CH_STX, 8'hFF};
      send_frame();
      frame_bytes = {8'h00};
      send_frame();
      frame_bytes = {8'hFF};
      send_frame();

      // Good text frames at the digit extremes, shortest layout and both cases.
      build_text(CH_ZERO, 0, CH_ETB, 1'b0);
      send_frame();
      build_text(CH_ZERO + 8'd7, 5, CH_ETX, 1'b1);
      send_frame();

      // Digit out of range, and its precedence over a missing LF.
      build_text(CH_ZERO + 8'd8, 3, CH_ETX, 1'b0);
      send_frame();
      build_text(CH_ZERO - 8'd1, 3, CH_ETB, 1'b0);
      poke(1, CH_CR);
      send_frame();

      // Missing final LF, and its precedence over a bad CR.
      build_text(CH_ZERO + 8'd2, 4, CH_ETB, 1'b1);
      poke(2, 8'h58);
      poke(1, CH_CR);
      send_frame();
      build_text(CH_ZERO + 8'd3, 2, CH_ETX, 1'b0);
      void'(frame_bytes.pop_back());
      send_frame();

      // Checksum characters just outside each hex range.
      build_text(CH_ZERO + 8'd1, 2, CH_ETX, 1'b0);
      poke(3, CH_NINE + 8'd1);
      send_frame();
      build_text(CH_ZERO + 8'd1, 2, CH_ETX, 1'b0);
      poke(4, CH_UPPER_A - 8'd1);
      send_frame();
      build_text(CH_ZERO + 8'd1, 2, CH_ETX, 1'b0);
      poke(3, CH_UPPER_F + 8'd1);
      send_frame();
      build_text(CH_ZERO + 8'd1, 2, CH_ETX, 1'b1);
      poke(4, CH_LOWER_A - 8'd1);
      send_frame();
      build_text(CH_ZERO + 8'd1, 2, CH_ETX, 1'b1);
      poke(3, CH_LOWER_F + 8'd1);
      send_frame();

      // Wrong closer, wrong CR before it, and a payload that no longer matches the sum.
      build_text(CH_ZERO + 8'd4, 2, CH_ETX, 1'b0);
      poke(5, CH_EOT);
      send_frame();
      build_text(CH_ZERO + 8'd4, 2, CH_ETB, 1'b0);
      poke(6, CH_LF);
      send_frame();
      build_text(CH_ZERO + 8'd5, 3, CH_ETB, 1'b0);
      frame_bytes[2] = frame_bytes[2] + 8'd1;
      send_frame();

      // Buffers that are too short or too long; the long one also saturates the count.
      frame_bytes = {CH_STX};
      send_frame();
      build_text(CH_ZERO, 0, CH_ETB, 1'b0);
      void'(frame_bytes.pop_front());
      frame_bytes.push_front(CH_STX);
      frame_bytes.delete(7);
      send_frame();
      build_text(CH_ZERO + 8'd6, MAX_BYTES - MIN_TEXT_BYTES + 2, CH_ETX, 1'b0);
      send_frame();

      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS / 2) send_random_buffer();

      // Hold the result side for a long stretch while single-byte frames keep coming,
      // so that the block fills up and stops taking beats.
      hold_wanted = 1'b1;
      wait (hold_active);
      steady_sender = 1'b1;
      repeat (60) begin
         frame_bytes = {control_char($urandom_range(0, 3))};
         send_frame();
      end
      steady_sender = 1'b0;

      while (beats_sent - start_beats < RANDOM_BEATS) send_random_buffer();

      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("PASS astm_e1381_frame_parser");
      else
         $display("FAIL astm_e1381_frame_parser");
      $finish;
   end

endmodule
